[src/lsp_pkg.sv]
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants for the LIFO stack with threshold purge.
// ----------------------------------------------------------------------------
`default_nettype none

package lsp_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_W        = 32;
   localparam int ENTRY_COUNT_W = 5;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PURGE = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

endpackage

`default_nettype wire

[src/lifo_stack_with_threshold_purge.sv]
// ----------------------------------------------------------------------------
// lifo_stack_with_threshold_purge
// Bounded LIFO of signed 32-bit words with push, pop, purge-below-limit and
// clear.
//
// Input beat: taken on a rising edge with start high and busy low;
// req_operation selects the operation, req_value is the pushed word or the
// purge limit. Every input beat yields one result beat: rsp_strobe is high
// for exactly one cycle and the receiver cannot hold it off.
// Result and occupancy (N = entries held before the operation):
//   push, clear     : result registered on accept, busy stays low.
//   pop             : result registered on accept, busy, unless empty, while the
//                     new top is fetched from the word memory.
//   purge           : N = 0 is answered like clear; otherwise the walk reads
//                     one entry per cycle through the memory read port and
//                     compacts survivors in place, result when the walk ends,
//                     busy for the whole walk.
// Reset (synchronous, active high) empties the stack; memory contents are
// not cleared and need not be.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_with_threshold_purge
   import lsp_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [1:0]               req_operation,
   input  wire logic signed [WORD_W-1:0] req_value,
   output logic                          rsp_strobe,
   output logic signed [WORD_W-1:0]      rsp_read_value,
   output logic [ENTRY_COUNT_W-1:0]      rsp_entry_count,
   output logic                          rsp_is_empty,
   output logic                          rsp_is_full,
   output logic [1:0]                    rsp_status
);

   localparam int CntW  = $clog2(DEPTH + 1);
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_PURGE
   } state_type;

   state_type         state_ff, state_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic [WORD_W-1:0] top_ff, top_in;
   logic [CntW-1:0]   rd_ff, rd_in;
   logic [CntW-1:0]   wr_ff, wr_in;
   logic [WORD_W-1:0] last_ff, last_in;
   logic signed [WORD_W-1:0] limit_ff, limit_in;

   logic              strobe_ff, strobe_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic [CntW-1:0]   rsp_count_ff, rsp_count_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              ram_we;
   logic [AddrW-1:0]  ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AddrW-1:0]  ram_raddr;
   logic [WORD_W-1:0] ram_rdata;

   logic              accept;
   op_type            op;
   logic              is_full_now;
   logic [CntW-1:0]   cnt_m1;
   logic [CntW-1:0]   cnt_m2;
   logic [CntW-1:0]   rd_inc;
   logic              keep;
   logic [CntW-1:0]   wr_next;
   logic [WORD_W-1:0] last_next;
   logic [CntW+ENTRY_COUNT_W-1:0] cnt_ext;

   lsp_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy        = (state_ff != S_IDLE);
   assign accept      = start && !busy;
   assign op          = op_type'(req_operation);
   assign is_full_now = (count_ff == CntW'(DEPTH));
   assign cnt_m1      = count_ff - CntW'(1);
   assign cnt_m2      = count_ff - CntW'(2);
   assign rd_inc      = rd_ff + CntW'(1);
   assign keep        = !($signed(ram_rdata) < limit_ff);
   assign wr_next     = wr_ff + CntW'(keep);
   assign last_next   = keep ? ram_rdata : last_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      last_in       = last_ff;
      limit_in      = limit_ff;
      strobe_in     = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = count_ff[AddrW-1:0];
      ram_wdata     = req_value;
      ram_re        = 1'b0;
      ram_raddr     = cnt_m2[AddrW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               strobe_in     = 1'b1;
               rsp_status_in = ST_OK;
               unique case (op)
                  OP_PUSH: begin
                     if (is_full_now) begin
                        rsp_value_in  = top_ff;
                        rsp_count_in  = count_ff;
                        rsp_status_in = ST_OVERFLOW;
                     end else begin
                        ram_we       = 1'b1;
                        top_in       = req_value;
                        count_in     = count_ff + CntW'(1);
                        rsp_value_in = req_value;
                        rsp_count_in = count_ff + CntW'(1);
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_value_in  = '0;
                        rsp_count_in  = '0;
                        rsp_status_in = ST_UNDERFLOW;
                     end else begin
                        rsp_value_in = top_ff;
                        rsp_count_in = cnt_m1;
                        count_in     = cnt_m1;
                        ram_re       = (count_ff > CntW'(1));
                        state_in     = S_POP;
                     end
                  end
                  OP_PURGE: begin
                     if (count_ff == '0) begin
                        rsp_value_in = '0;
                        rsp_count_in = '0;
                     end else begin
                        strobe_in = 1'b0;
                        limit_in  = req_value;
                        rd_in     = '0;
                        wr_in     = '0;
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        state_in  = S_PURGE;
                     end
                  end
                  OP_CLEAR: begin
                     count_in     = '0;
                     rsp_value_in = '0;
                     rsp_count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_POP: begin
            top_in   = ram_rdata;
            state_in = S_IDLE;
         end
         S_PURGE: begin
            ram_we    = keep;
            ram_waddr = wr_ff[AddrW-1:0];
            ram_wdata = ram_rdata;
            if (rd_ff == cnt_m1) begin
               count_in      = wr_next;
               top_in        = last_next;
               strobe_in     = 1'b1;
               rsp_value_in  = (wr_next == '0) ? '0 : last_next;
               rsp_count_in  = wr_next;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end else begin
               rd_in     = rd_inc;
               wr_in     = wr_next;
               last_in   = last_next;
               ram_re    = 1'b1;
               ram_raddr = rd_inc[AddrW-1:0];
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      top_ff        <= top_in;
      rd_ff         <= rd_in;
      wr_ff         <= wr_in;
      last_ff       <= last_in;
      limit_ff      <= limit_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign cnt_ext         = (CntW+ENTRY_COUNT_W)'(rsp_count_ff);
   assign rsp_strobe      = strobe_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_entry_count = cnt_ext[ENTRY_COUNT_W-1:0];
   assign rsp_is_empty    = (rsp_count_ff == '0);
   assign rsp_is_full     = (rsp_count_ff == CntW'(DEPTH));
   assign rsp_status      = rsp_status_ff;

   // count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("stack count above capacity");

   // non-purge beats answer in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (accept && (op != OP_PURGE)) |=> rsp_strobe)
      else $error("missing result beat");

   // compaction write pointer never passes the read pointer
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PURGE) |-> (wr_ff <= rd_ff))
      else $error("purge write pointer ahead of read pointer");

   // no result beat while a purge walk is still running
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PURGE) && (rd_ff != cnt_m1) |=> !rsp_strobe)
      else $error("result beat during purge walk");

endmodule

`default_nettype wire

[src/lsp_ram.sv]
// ----------------------------------------------------------------------------
// lsp_ram
// Stack word storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_ram
   import lsp_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AddrW-1:0]  wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AddrW-1:0]  rd_addr,
   output logic      [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
